// File: rtl/core/spq_pkg.sv
// Shared types, constants and helper functions for the strict-priority
// transmit descriptor queues. No dependencies.
package spq_pkg;

    localparam int QUEUE_DEPTH   = 8;
    localparam int FRAME_LEN_MAX = 512;
    localparam int NUM_LEVELS    = 3;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 10;
    localparam int LVL_W   = 2;
    localparam int STAT_W  = 3;
    localparam int DEPTH_W = 4;
    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOTS   = NUM_LEVELS * QUEUE_DEPTH;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic             OP_ENQ       = 1'b0;
    localparam logic             OP_DEQ       = 1'b1;
    localparam logic [LVL_W-1:0] PRIO_INVALID = 2'd3;

    typedef enum logic [STAT_W-1:0] {
        ST_ENQUEUED = 3'd0,
        ST_DROPPED  = 3'd1,
        ST_POPPED   = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_BAD_PRIO = 3'd4
    } t_status;

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [LVL_W-1:0] t_lvl;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_kind;
        logic [BYTE_W-1:0] frame_flags;
        logic [BYTE_W-1:0] frame_seq;
        logic [BYTE_W-1:0] frame_cmd;
        logic [LEN_W-1:0]  frame_len;
    } t_desc;

    typedef struct packed {
        logic  opcode;
        t_lvl  priority_req;
        t_desc desc;
    } t_item;

    typedef struct packed {
        t_status             status;
        t_lvl                out_priority;
        t_desc               desc;
        logic [DEPTH_W-1:0]  depth_high;
        logic [DEPTH_W-1:0]  depth_normal;
        logic [DEPTH_W-1:0]  depth_low;
        logic [DEPTH_W-1:0]  peak_touched;
    } t_result;

    typedef struct packed {
        logic  wr_en;
        t_lvl  wr_lvl;
        t_ptr  wr_ptr;
        t_desc wr_data;
        t_lvl  rd_lvl;
        t_ptr  rd_ptr;
    } t_store_req;

    function automatic t_ptr ptr_next(input t_ptr p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    function automatic logic [DEPTH_W-1:0] to_depth(input t_cnt c);
        logic [CNT_W+DEPTH_W-1:0] wide;
        wide = (CNT_W + DEPTH_W)'(c);
        return wide[DEPTH_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] slot_idx(input t_lvl l, input t_ptr p);
        return SLOT_W'(l) * SLOT_W'(QUEUE_DEPTH) + SLOT_W'(p);
    endfunction

endpackage

// File: rtl/core/spq_store.sv
// Descriptor slot register file for all three queues, one write and one read port.
// Depends on spq_pkg.
module spq_store (
    input  logic                i_clk,
    input  spq_pkg::t_store_req i_req,
    output spq_pkg::t_desc      o_rd_data
);
    import spq_pkg::*;

    t_desc r_slot [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_slot[slot_idx(i_req.wr_lvl, i_req.wr_ptr)] <= i_req.wr_data;
        end
    end

    assign o_rd_data = r_slot[slot_idx(i_req.rd_lvl, i_req.rd_ptr)];

endmodule

// File: rtl/core/spq_ctrl.sv
// Queue pointers, fill counts and watermarks, plus the per-item enqueue and
// strict-priority dequeue decision. Depends on spq_pkg.
module spq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  spq_pkg::t_item      i_item,
    input  spq_pkg::t_desc      i_rd_data,
    output spq_pkg::t_store_req o_req,
    output spq_pkg::t_result    o_res
);
    import spq_pkg::*;

    t_ptr r_head [NUM_LEVELS];
    t_ptr r_tail [NUM_LEVELS];
    t_cnt r_count [NUM_LEVELS];
    t_cnt r_peak [NUM_LEVELS];
    t_ptr n_head [NUM_LEVELS];
    t_ptr n_tail [NUM_LEVELS];
    t_cnt n_count [NUM_LEVELS];
    t_cnt n_peak [NUM_LEVELS];

    t_desc wr_desc;
    t_cnt  peak;
    logic  found;
    logic  wr_en;

    always_comb begin
        wr_desc = i_item.desc;
        if (i_item.desc.frame_len > LEN_W'(FRAME_LEN_MAX)) begin
            wr_desc.frame_len = LEN_W'(FRAME_LEN_MAX);
        end
    end

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_peak  = r_peak;
        o_res   = '0;
        o_res.status = ST_EMPTY;
        peak    = '0;
        found   = 1'b0;
        wr_en   = 1'b0;
        o_req   = '0;
        o_req.wr_data = wr_desc;
        if (i_item.opcode == OP_ENQ) begin
            if (i_item.priority_req == PRIO_INVALID) begin
                o_res.status = ST_BAD_PRIO;
            end else begin
                for (int l = 0; l < NUM_LEVELS; l++) begin
                    if (i_item.priority_req == LVL_W'(l)) begin
                        o_res.out_priority = i_item.priority_req;
                        if (r_count[l] == CNT_W'(QUEUE_DEPTH)) begin
                            o_res.status = ST_DROPPED;
                            peak = r_peak[l];
                        end else begin
                            o_res.status = ST_ENQUEUED;
                            wr_en        = 1'b1;
                            o_req.wr_lvl = LVL_W'(l);
                            o_req.wr_ptr = r_tail[l];
                            n_tail[l]    = ptr_next(r_tail[l]);
                            n_count[l]   = r_count[l] + CNT_W'(1);
                            if (n_count[l] > r_peak[l]) begin
                                n_peak[l] = n_count[l];
                            end
                            peak = n_peak[l];
                        end
                    end
                end
            end
        end else begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                if (!found && r_count[l] != '0) begin
                    found              = 1'b1;
                    o_res.status       = ST_POPPED;
                    o_res.out_priority = LVL_W'(l);
                    o_req.rd_lvl       = LVL_W'(l);
                    o_req.rd_ptr       = r_head[l];
                    n_head[l]          = ptr_next(r_head[l]);
                    n_count[l]         = r_count[l] - CNT_W'(1);
                    peak               = r_peak[l];
                end
            end
            if (found) begin
                o_res.desc = i_rd_data;
            end
        end
        o_req.wr_en        = wr_en & i_fire;
        o_res.depth_high   = to_depth(n_count[0]);
        o_res.depth_normal = to_depth(n_count[1]);
        o_res.depth_low    = to_depth(n_count[2]);
        o_res.peak_touched = to_depth(peak);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
                r_peak[l]  <= '0;
            end
        end else if (i_fire) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_peak  <= n_peak;
        end
    end

endmodule

// File: rtl/core/strict_priority_tx_queues.sv
// Three strict-priority ring queues of transmit frame descriptors (high, normal,
// low), each QUEUE_DEPTH entries deep. Every accepted beat yields exactly one
// result beat: it is held in an input register, then passes through the queue
// control and slot file into the result register, which drives the outputs. One
// beat is accepted every cycle while the result side keeps up; queue state
// updates as a beat leaves the input register, so back-to-back beats see each
// other's effects.
// Depends on spq_pkg, spq_ctrl and spq_store.
module strict_priority_tx_queues (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_opcode,
    input  logic [spq_pkg::LVL_W-1:0]           i_priority_req,
    input  logic [spq_pkg::BYTE_W-1:0]          i_frame_kind,
    input  logic [spq_pkg::BYTE_W-1:0]          i_frame_flags,
    input  logic [spq_pkg::BYTE_W-1:0]          i_frame_seq,
    input  logic [spq_pkg::BYTE_W-1:0]          i_frame_cmd,
    input  logic [spq_pkg::LEN_W-1:0]           i_frame_len,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [spq_pkg::STAT_W-1:0]          o_status,
    output logic [spq_pkg::LVL_W-1:0]           o_out_priority,
    output logic [spq_pkg::BYTE_W-1:0]          o_out_type,
    output logic [spq_pkg::BYTE_W-1:0]          o_out_flags,
    output logic [spq_pkg::BYTE_W-1:0]          o_out_seq,
    output logic [spq_pkg::BYTE_W-1:0]          o_out_cmd,
    output logic [spq_pkg::LEN_W-1:0]           o_out_len,
    output logic [spq_pkg::DEPTH_W-1:0]         o_depth_high,
    output logic [spq_pkg::DEPTH_W-1:0]         o_depth_normal,
    output logic [spq_pkg::DEPTH_W-1:0]         o_depth_low,
    output logic [spq_pkg::DEPTH_W-1:0]         o_peak_touched
);
    import spq_pkg::*;

    logic       r_in_valid;
    t_item      r_in;
    logic       r_out_valid;
    t_result    r_res;
    logic       adv;
    logic       accept;
    t_store_req req;
    t_desc      rd_data;
    t_result    res;

    assign adv     = r_in_valid & (~r_out_valid | i_ready);
    assign o_ready = ~r_in_valid | adv;
    assign accept  = i_valid & o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.opcode            <= i_opcode;
            r_in.priority_req      <= i_priority_req;
            r_in.desc.frame_kind   <= i_frame_kind;
            r_in.desc.frame_flags  <= i_frame_flags;
            r_in.desc.frame_seq    <= i_frame_seq;
            r_in.desc.frame_cmd    <= i_frame_cmd;
            r_in.desc.frame_len    <= i_frame_len;
        end
        if (adv) begin
            r_res <= res;
        end
    end

    spq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (adv),
        .i_item    (r_in),
        .i_rd_data (rd_data),
        .o_req     (req),
        .o_res     (res)
    );

    spq_store u_store (
        .i_clk     (i_clk),
        .i_req     (req),
        .o_rd_data (rd_data)
    );

    assign o_valid        = r_out_valid;
    assign o_status       = r_res.status;
    assign o_out_priority = r_res.out_priority;
    assign o_out_type     = r_res.desc.frame_kind;
    assign o_out_flags    = r_res.desc.frame_flags;
    assign o_out_seq      = r_res.desc.frame_seq;
    assign o_out_cmd      = r_res.desc.frame_cmd;
    assign o_out_len      = r_res.desc.frame_len;
    assign o_depth_high   = r_res.depth_high;
    assign o_depth_normal = r_res.depth_normal;
    assign o_depth_low    = r_res.depth_low;
    assign o_peak_touched = r_res.peak_touched;

endmodule

// File: verif/spq_order_monitor.sv
`timescale 1ns / 100ps
// Monitor for strict_priority_tx_queues: predicts every result beat from the
// request beats it sees and compares them in order. Depends on spq_pkg.
module spq_order_monitor (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_opcode,
    input  logic [spq_pkg::LVL_W-1:0]    i_priority_req,
    input  logic [spq_pkg::BYTE_W-1:0]   i_frame_kind,
    input  logic [spq_pkg::BYTE_W-1:0]   i_frame_flags,
    input  logic [spq_pkg::BYTE_W-1:0]   i_frame_seq,
    input  logic [spq_pkg::BYTE_W-1:0]   i_frame_cmd,
    input  logic [spq_pkg::LEN_W-1:0]    i_frame_len,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [spq_pkg::STAT_W-1:0]   i_status,
    input  logic [spq_pkg::LVL_W-1:0]    i_out_priority,
    input  logic [spq_pkg::BYTE_W-1:0]   i_out_type,
    input  logic [spq_pkg::BYTE_W-1:0]   i_out_flags,
    input  logic [spq_pkg::BYTE_W-1:0]   i_out_seq,
    input  logic [spq_pkg::BYTE_W-1:0]   i_out_cmd,
    input  logic [spq_pkg::LEN_W-1:0]    i_out_len,
    input  logic [spq_pkg::DEPTH_W-1:0]  i_depth_high,
    input  logic [spq_pkg::DEPTH_W-1:0]  i_depth_normal,
    input  logic [spq_pkg::DEPTH_W-1:0]  i_depth_low,
    input  logic [spq_pkg::DEPTH_W-1:0]  i_peak_touched,
    output int unsigned                  o_mismatches,
    output int unsigned                  o_pending
);
    import spq_pkg::*;

    t_desc       slots [NUM_LEVELS][QUEUE_DEPTH];
    int unsigned rd_idx [NUM_LEVELS];
    int unsigned wr_idx [NUM_LEVELS];
    int unsigned fill [NUM_LEVELS];
    int unsigned peak [NUM_LEVELS];
    t_result     due_results [$];
    int unsigned errs = 0;
    int unsigned due_cnt = 0;

    assign o_mismatches = errs;
    assign o_pending    = due_cnt;

    function automatic t_result serve_request(input logic op, input t_lvl prio,
                                              input t_desc d);
        t_result r;
        int      lvl;
        bit      found;
        r        = '0;
        r.status = ST_EMPTY;
        found    = 1'b0;
        if (op == OP_ENQ) begin
            if (prio == PRIO_INVALID) begin
                r.status = ST_BAD_PRIO;
            end else begin
                lvl            = int'(prio);
                r.out_priority = prio;
                if (fill[lvl] >= QUEUE_DEPTH) begin
                    r.status = ST_DROPPED;
                end else begin
                    if (d.frame_len > FRAME_LEN_MAX) begin
                        d.frame_len = LEN_W'(FRAME_LEN_MAX);
                    end
                    slots[lvl][wr_idx[lvl]] = d;
                    wr_idx[lvl] = (wr_idx[lvl] + 1) % QUEUE_DEPTH;
                    fill[lvl]++;
                    if (fill[lvl] > peak[lvl]) begin
                        peak[lvl] = fill[lvl];
                    end
                    r.status = ST_ENQUEUED;
                end
                r.peak_touched = DEPTH_W'(peak[lvl]);
            end
        end else begin
            for (int q = 0; q < NUM_LEVELS; q++) begin
                if (!found && fill[q] != 0) begin
                    r.desc = slots[q][rd_idx[q]];
                    rd_idx[q] = (rd_idx[q] + 1) % QUEUE_DEPTH;
                    fill[q]--;
                    r.status       = ST_POPPED;
                    r.out_priority = t_lvl'(q);
                    r.peak_touched = DEPTH_W'(peak[q]);
                    found          = 1'b1;
                end
            end
        end
        r.depth_high   = DEPTH_W'(fill[0]);
        r.depth_normal = DEPTH_W'(fill[1]);
        r.depth_low    = DEPTH_W'(fill[2]);
        return r;
    endfunction

    task automatic check_field(input string nm, input int unsigned want,
                               input logic [15:0] got);
        if (got !== 16'(want)) begin
            errs++;
            if (errs <= 10) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, want, got);
            end
        end
    endtask

    task automatic compare_beat();
        t_result want;
        if (due_results.size() == 0) begin
            errs++;
            if (errs <= 10) begin
                $display("%0t: result beat with no request outstanding", $time);
            end
        end else begin
            want = due_results.pop_front();
            check_field("status", 32'(want.status), 16'(i_status));
            check_field("out_priority", 32'(want.out_priority), 16'(i_out_priority));
            check_field("out_type", 32'(want.desc.frame_kind), 16'(i_out_type));
            check_field("out_flags", 32'(want.desc.frame_flags), 16'(i_out_flags));
            check_field("out_seq", 32'(want.desc.frame_seq), 16'(i_out_seq));
            check_field("out_cmd", 32'(want.desc.frame_cmd), 16'(i_out_cmd));
            check_field("out_len", 32'(want.desc.frame_len), 16'(i_out_len));
            check_field("depth_high", 32'(want.depth_high), 16'(i_depth_high));
            check_field("depth_normal", 32'(want.depth_normal), 16'(i_depth_normal));
            check_field("depth_low", 32'(want.depth_low), 16'(i_depth_low));
            check_field("peak_touched", 32'(want.peak_touched), 16'(i_peak_touched));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_LEVELS; q++) begin
                rd_idx[q] = 0;
                wr_idx[q] = 0;
                fill[q]   = 0;
                peak[q]   = 0;
            end
            due_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                compare_beat();
            end
            if (i_in_valid && i_in_ready) begin
                due_results.push_back(serve_request(i_opcode, i_priority_req,
                    {i_frame_kind, i_frame_flags, i_frame_seq, i_frame_cmd, i_frame_len}));
            end
        end
        due_cnt = due_results.size();
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Top of the strict_priority_tx_queues testbench: clock, reset, request and
// result traffic, verdict. Depends on spq_pkg, the block and spq_order_monitor.
module tb_top;
    import spq_pkg::*;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_valid        = 1'b0;
    logic                i_opcode       = 1'b0;
    logic [LVL_W-1:0]    i_priority_req = '0;
    logic [BYTE_W-1:0]   i_frame_kind   = '0;
    logic [BYTE_W-1:0]   i_frame_flags  = '0;
    logic [BYTE_W-1:0]   i_frame_seq    = '0;
    logic [BYTE_W-1:0]   i_frame_cmd    = '0;
    logic [LEN_W-1:0]    i_frame_len    = '0;
    logic                i_ready        = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [STAT_W-1:0]   o_status;
    logic [LVL_W-1:0]    o_out_priority;
    logic [BYTE_W-1:0]   o_out_type;
    logic [BYTE_W-1:0]   o_out_flags;
    logic [BYTE_W-1:0]   o_out_seq;
    logic [BYTE_W-1:0]   o_out_cmd;
    logic [LEN_W-1:0]    o_out_len;
    logic [DEPTH_W-1:0]  o_depth_high;
    logic [DEPTH_W-1:0]  o_depth_normal;
    logic [DEPTH_W-1:0]  o_depth_low;
    logic [DEPTH_W-1:0]  o_peak_touched;
    int unsigned         mismatches;
    int unsigned         in_flight;
    bit                  burst = 1'b0;

    always #5 i_clk = ~i_clk;

    strict_priority_tx_queues DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_priority_req (i_priority_req),
        .i_frame_kind   (i_frame_kind),
        .i_frame_flags  (i_frame_flags),
        .i_frame_seq    (i_frame_seq),
        .i_frame_cmd    (i_frame_cmd),
        .i_frame_len    (i_frame_len),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_out_priority (o_out_priority),
        .o_out_type     (o_out_type),
        .o_out_flags    (o_out_flags),
        .o_out_seq      (o_out_seq),
        .o_out_cmd      (o_out_cmd),
        .o_out_len      (o_out_len),
        .o_depth_high   (o_depth_high),
        .o_depth_normal (o_depth_normal),
        .o_depth_low    (o_depth_low),
        .o_peak_touched (o_peak_touched)
    );

    spq_order_monitor u_order_mon (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_opcode       (i_opcode),
        .i_priority_req (i_priority_req),
        .i_frame_kind   (i_frame_kind),
        .i_frame_flags  (i_frame_flags),
        .i_frame_seq    (i_frame_seq),
        .i_frame_cmd    (i_frame_cmd),
        .i_frame_len    (i_frame_len),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_status       (o_status),
        .i_out_priority (o_out_priority),
        .i_out_type     (o_out_type),
        .i_out_flags    (o_out_flags),
        .i_out_seq      (o_out_seq),
        .i_out_cmd      (o_out_cmd),
        .i_out_len      (o_out_len),
        .i_depth_high   (o_depth_high),
        .i_depth_normal (o_depth_normal),
        .i_depth_low    (o_depth_low),
        .i_peak_touched (o_peak_touched),
        .o_mismatches   (mismatches),
        .o_pending      (in_flight)
    );

    function automatic t_desc random_desc();
        t_desc d;
        d.frame_kind  = BYTE_W'($urandom);
        d.frame_flags = BYTE_W'($urandom);
        d.frame_seq   = BYTE_W'($urandom);
        d.frame_cmd   = BYTE_W'($urandom);
        if ($urandom_range(0, 7) == 0) begin
            d.frame_len = LEN_W'($urandom_range(FRAME_LEN_MAX + 1, 1023));
        end else begin
            d.frame_len = LEN_W'($urandom_range(0, FRAME_LEN_MAX));
        end
        return d;
    endfunction

    task automatic offer_request(input logic op, input t_lvl prio, input t_desc d);
        int unsigned gap;
        gap = burst ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= op;
        i_priority_req <= prio;
        i_frame_kind   <= d.frame_kind;
        i_frame_flags  <= d.frame_flags;
        i_frame_seq    <= d.frame_seq;
        i_frame_cmd    <= d.frame_cmd;
        i_frame_len    <= d.frame_len;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic pop_request();
        offer_request(OP_DEQ, t_lvl'($urandom_range(0, 3)), random_desc());
    endtask

    initial begin : limit
        #3_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Result side: random stalls, plus two long hold-offs to back the block up.
    initial begin : sink
        int unsigned stall;
        int unsigned taken;
        taken = 0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (taken == 120 || taken == 560) begin
                stall = 90;
            end else if (burst) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 6);
            end
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            taken++;
        end
    end

    initial begin : stimulus
        t_desc d;
        int    mix;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        pop_request();
        offer_request(OP_ENQ, PRIO_INVALID, '1);
        d = '1;
        offer_request(OP_ENQ, t_lvl'(2), d);
        d.frame_len = LEN_W'(FRAME_LEN_MAX + 1);
        offer_request(OP_ENQ, t_lvl'(1), d);
        offer_request(OP_ENQ, t_lvl'(0), '0);
        d.frame_len = LEN_W'(FRAME_LEN_MAX);
        offer_request(OP_ENQ, t_lvl'(0), d);
        repeat (5) pop_request();
        for (int k = 0; k <= QUEUE_DEPTH; k++) begin
            offer_request(OP_ENQ, t_lvl'(1), random_desc());
        end
        repeat (4) pop_request();

        for (int phase = 0; phase < 15; phase++) begin
            burst = (phase % 4 == 3);
            case (phase % 3)
                0: mix = 80;
                1: mix = 20;
                default: mix = 50;
            endcase
            repeat (55) begin
                if ($urandom_range(0, 99) < mix) begin
                    if ($urandom_range(0, 19) == 0) begin
                        offer_request(OP_ENQ, PRIO_INVALID, random_desc());
                    end else begin
                        offer_request(OP_ENQ, t_lvl'($urandom_range(0, 2)), random_desc());
                    end
                end else begin
                    pop_request();
                end
            end
        end
        burst = 1'b0;
        i_valid <= 1'b0;
        @(posedge i_clk);

        while (in_flight != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && in_flight == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
